### sv/char_lcd_nibble_queue_controller_macros.svh
// Assertion macros shared by the character LCD queue controller RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CHAR_LCD_NIBBLE_QUEUE_CONTROLLER_MACROS_SVH
`define CHAR_LCD_NIBBLE_QUEUE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CLNQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clnq: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CLNQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clnq: next-cycle check failed");

`endif

### sv/clnq_pkg.sv
// Shared types, codes and constants for the character LCD queue controller.
// Used by clnq_ctrl, clnq_datapath and the top level; depends on nothing.
package clnq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 256;

  // Request codes
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_SET_CURSOR = 3'd1;
  localparam logic [2:0] CMD_PUT_AT     = 3'd2;
  localparam logic [2:0] CMD_STREAM     = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;
  localparam logic [2:0] CMD_CGRAM      = 3'd5;
  localparam logic [2:0] CMD_RAW        = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [1:0] CFG_ENABLE   = 2'd2;

  localparam logic [2:0] NUM_ROWS_RST = 3'd2;
  localparam logic [5:0] NUM_COLS_RST = 6'd16;
  localparam logic       ENABLE_RST   = 1'b1;

  // Controller instruction bytes and special characters
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
  localparam logic [7:0] DISP_CLEAR    = 8'h01;
  localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
  localparam logic [7:0] CHAR_RETURN   = 8'd13;

  // Which byte the datapath stages for the next queue write
  typedef enum logic [2:0] {
    PREP_NONE,
    PREP_MOVE_TARGET,
    PREP_MOVE_NEXT,
    PREP_MOVE_HOME,
    PREP_DATA,
    PREP_RAW,
    PREP_CLEAR,
    PREP_CGRAM
  } prep_e;

  typedef struct packed {
    logic       load_item;
    prep_e      prep;
    logic       push_hi;
    logic       push_lo;
    logic       set_status;
    logic [1:0] status_val;
    logic       tick_read;
    logic       tick_apply;
    logic       strobe_fall;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       first;
    logic       char_nl;
    logic       char_cr;
    logic       slot_bad;
    logic       pos_differs;
    logic       col_over;
    logic       room_ok;
    logic       enable;
    logic       strobe_high;
    logic       queue_empty;
  } dp_stat_t;

  // DDRAM start address of each display row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

endpackage

### sv/clnq_datapath.sv
// Datapath of the character LCD queue controller: item and config registers,
// cursor, nibble queue memory, pin levels and result registers. Uses clnq_pkg.
`include "char_lcd_nibble_queue_controller_macros.svh"

module clnq_datapath #(
  parameter int unsigned QUEUE_DEPTH = clnq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [5:0]            cfg_data_i,
  input  logic [2:0]            cmd_i,
  input  logic [2:0]            row_i,
  input  logic [5:0]            col_i,
  input  logic [7:0]            char_code_i,
  input  logic                  first_i,
  input  logic [3:0]            cgram_index_i,
  input  clnq_pkg::ctrl_cmd_t   ctrl_i,
  output clnq_pkg::dp_stat_t    stat_o,
  output logic [1:0]            status_o,
  output logic                  pin_en_o,
  output logic                  pin_rs_o,
  output logic [3:0]            pin_data_o,
  output logic [1:0]            cursor_row_o,
  output logic [7:0]            cursor_col_o,
  output logic [8:0]            queue_level_o
);
  import clnq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(QUEUE_DEPTH - 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Item fields
  logic [2:0] cmd_q;
  logic [2:0] row_q;
  logic [5:0] col_q;
  logic [7:0] ch_q;
  logic       first_q;
  logic [3:0] slot_q;

  // Configuration
  logic [2:0] num_rows_q;
  logic [5:0] num_cols_q;
  logic       enable_q;

  // Queue and pins
  logic [4:0]       mem_q [QUEUE_DEPTH];
  logic [4:0]       rdata_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             strobe_q, strobe_d;
  logic             rs_q, rs_d;
  logic [3:0]       data_q, data_d;
  logic [1:0]       cur_row_q, cur_row_d;
  logic [7:0]       cur_col_q, cur_col_d;
  logic [1:0]       status_q;

  // Staged byte and the cursor it leaves behind
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       pend_rs_q, pend_rs_d;
  logic       pend_upd_q, pend_upd_d;
  logic [1:0] pend_row_q, pend_row_d;
  logic [7:0] pend_col_q, pend_col_d;

  // Result registers
  logic [1:0] out_status_q;
  logic       out_en_q;
  logic       out_rs_q;
  logic [3:0] out_data_q;
  logic [1:0] out_row_q;
  logic [7:0] out_col_q;
  logic [8:0] out_level_q;

  logic [2:0]       mv_row;
  logic [7:0]       mv_col;
  logic [1:0]       norm_row;
  logic [7:0]       mv_addr;
  logic             push;
  logic [4:0]       wdata;
  logic [CNT_W+8:0] level_ext;

  // Cursor move address
  always_comb begin
    mv_row = row_q;
    mv_col = {2'b00, col_q};
    case (ctrl_i.prep)
      PREP_MOVE_NEXT: begin
        mv_row = {1'b0, cur_row_q} + 3'd1;
        mv_col = 8'd0;
      end
      PREP_MOVE_HOME: begin
        mv_row = {1'b0, cur_row_q};
        mv_col = 8'd0;
      end
      default: begin
        mv_row = row_q;
        mv_col = {2'b00, col_q};
      end
    endcase
    norm_row = (mv_row >= num_rows_q || mv_row > 3'd3) ? 2'd0 : mv_row[1:0];
    mv_addr  = LCD_SET_DDRAM | (mv_col + row_base(norm_row));
  end

  always_comb begin
    pend_byte_d = pend_byte_q;
    pend_rs_d   = pend_rs_q;
    pend_upd_d  = pend_upd_q;
    pend_row_d  = pend_row_q;
    pend_col_d  = pend_col_q;
    case (ctrl_i.prep)
      PREP_MOVE_TARGET, PREP_MOVE_NEXT, PREP_MOVE_HOME: begin
        pend_byte_d = mv_addr;
        pend_rs_d   = 1'b0;
        pend_upd_d  = 1'b1;
        pend_row_d  = norm_row;
        pend_col_d  = mv_col;
      end
      PREP_DATA: begin
        pend_byte_d = ch_q;
        pend_rs_d   = 1'b1;
        pend_upd_d  = 1'b1;
        pend_row_d  = cur_row_q;
        pend_col_d  = cur_col_q + 8'd1;
      end
      PREP_RAW: begin
        pend_byte_d = ch_q;
        pend_rs_d   = 1'b1;
        pend_upd_d  = 1'b0;
      end
      PREP_CLEAR: begin
        pend_byte_d = DISP_CLEAR;
        pend_rs_d   = 1'b0;
        pend_upd_d  = 1'b1;
        pend_row_d  = 2'd0;
        pend_col_d  = 8'd0;
      end
      PREP_CGRAM: begin
        pend_byte_d = LCD_SET_CGRAM | {2'b00, slot_q[2:0], 3'b000};
        pend_rs_d   = 1'b0;
        pend_upd_d  = 1'b0;
      end
      default: begin
        pend_byte_d = pend_byte_q;
      end
    endcase
  end

  assign push  = ctrl_i.push_hi | ctrl_i.push_lo;
  assign wdata = ctrl_i.push_hi ? {pend_rs_q, pend_byte_q[7:4]} : {pend_rs_q, pend_byte_q[3:0]};

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    strobe_d  = strobe_q;
    rs_d      = rs_q;
    data_d    = data_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    if (push) begin
      tail_d  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (ctrl_i.push_lo && pend_upd_q) begin
      cur_row_d = pend_row_q;
      cur_col_d = pend_col_q;
    end
    if (ctrl_i.strobe_fall) begin
      strobe_d = 1'b0;
    end
    if (ctrl_i.tick_apply) begin
      head_d   = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
      count_d  = count_q - 1'b1;
      rs_d     = rdata_q[4];
      data_d   = rdata_q[3:0];
      strobe_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      strobe_q   <= 1'b0;
      rs_q       <= 1'b0;
      data_q     <= 4'd0;
      cur_row_q  <= 2'd0;
      cur_col_q  <= 8'd0;
      status_q   <= ST_OK;
      num_rows_q <= NUM_ROWS_RST;
      num_cols_q <= NUM_COLS_RST;
      enable_q   <= ENABLE_RST;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      strobe_q  <= strobe_d;
      rs_q      <= rs_d;
      data_q    <= data_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      if (ctrl_i.load_item) begin
        status_q <= ST_OK;
      end else if (ctrl_i.set_status) begin
        status_q <= ctrl_i.status_val;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_ROWS: num_rows_q <= cfg_data_i[2:0];
          CFG_NUM_COLS: num_cols_q <= cfg_data_i;
          CFG_ENABLE:   enable_q   <= cfg_data_i[0];
          default:      enable_q   <= enable_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      cmd_q   <= cmd_i;
      row_q   <= row_i;
      col_q   <= col_i;
      ch_q    <= char_code_i;
      first_q <= first_i;
      slot_q  <= cgram_index_i;
    end
    pend_byte_q <= pend_byte_d;
    pend_rs_q   <= pend_rs_d;
    pend_upd_q  <= pend_upd_d;
    pend_row_q  <= pend_row_d;
    pend_col_q  <= pend_col_d;
    if (ctrl_i.load_out) begin
      out_status_q <= status_q;
      out_en_q     <= strobe_q;
      out_rs_q     <= rs_q;
      out_data_q   <= data_q;
      out_row_q    <= cur_row_q;
      out_col_q    <= cur_col_q;
      out_level_q  <= level_ext[8:0];
    end
  end

  // Nibble queue memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[tail_q] <= wdata;
    end
    if (ctrl_i.tick_read) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign level_ext = {9'd0, count_q};

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.first       = first_q;
    stat_o.char_nl     = (ch_q == CHAR_NEWLINE);
    stat_o.char_cr     = (ch_q == CHAR_RETURN);
    stat_o.slot_bad    = slot_q[3];
    stat_o.pos_differs = (cur_col_q != {2'b00, col_q}) || ({1'b0, cur_row_q} != row_q);
    stat_o.col_over    = (cur_col_q >= {2'b00, num_cols_q});
    stat_o.room_ok     = (count_q <= ROOM_MAX);
    stat_o.enable      = enable_q;
    stat_o.strobe_high = strobe_q;
    stat_o.queue_empty = (count_q == '0);
  end

  assign status_o      = out_status_q;
  assign pin_en_o      = out_en_q;
  assign pin_rs_o      = out_rs_q;
  assign pin_data_o    = out_data_q;
  assign cursor_row_o  = out_row_q;
  assign cursor_col_o  = out_col_q;
  assign queue_level_o = out_level_q;

  `CLNQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_FULL)
  `CLNQ_ASSERT_IMP(a_push_has_room, ctrl_i.push_hi, count_q <= ROOM_MAX)
  `CLNQ_ASSERT_IMP(a_tick_nonempty, ctrl_i.tick_apply, (count_q != '0) && !strobe_q)
  `CLNQ_ASSERT_NXT(a_tick_pops, ctrl_i.tick_apply, strobe_q && (count_q == $past(count_q) - 1'b1))

endmodule

### sv/clnq_ctrl.sv
// Sequencer of the character LCD queue controller: walks each request through
// its cursor moves and byte writes, and each tick through the queue read. Uses clnq_pkg.
module clnq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  clnq_pkg::dp_stat_t  stat_i,
  output clnq_pkg::ctrl_cmd_t ctrl_o
);
  import clnq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIRST,
    S_WRAP,
    S_FINAL,
    S_CHECK,
    S_HI,
    S_LO,
    S_TICK,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.prep = PREP_NONE;
    state_d     = state_q;
    ret_d       = ret_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_item = 1'b1;
          state_d          = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_TICK: begin
            if (!stat_i.enable) begin
              state_d = S_OUT;
            end else if (stat_i.strobe_high) begin
              ctrl_o.strobe_fall = 1'b1;
              state_d            = S_OUT;
            end else if (stat_i.queue_empty) begin
              state_d = S_OUT;
            end else begin
              ctrl_o.tick_read = 1'b1;
              state_d          = S_TICK;
            end
          end
          CMD_SET_CURSOR: begin
            ctrl_o.prep = PREP_MOVE_TARGET;
            ret_d       = S_OUT;
            state_d     = S_CHECK;
          end
          CMD_PUT_AT: begin
            state_d = S_FIRST;
          end
          CMD_STREAM: begin
            state_d = stat_i.first ? S_FIRST : S_WRAP;
          end
          CMD_CLEAR: begin
            ctrl_o.prep = PREP_CLEAR;
            ret_d       = S_OUT;
            state_d     = S_CHECK;
          end
          CMD_CGRAM: begin
            if (stat_i.slot_bad) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status_val = ST_BAD_SLOT;
              state_d           = S_OUT;
            end else begin
              ctrl_o.prep = PREP_CGRAM;
              ret_d       = S_OUT;
              state_d     = S_CHECK;
            end
          end
          CMD_RAW: begin
            ctrl_o.prep = PREP_RAW;
            ret_d       = S_OUT;
            state_d     = S_CHECK;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_FIRST: begin
        if (stat_i.pos_differs) begin
          ctrl_o.prep = PREP_MOVE_TARGET;
          ret_d       = (stat_i.cmd == CMD_STREAM) ? S_WRAP : S_FINAL;
          state_d     = S_CHECK;
        end else begin
          state_d = (stat_i.cmd == CMD_STREAM) ? S_WRAP : S_FINAL;
        end
      end
      S_WRAP: begin
        // past the last column: go to the start of the next row
        if (stat_i.col_over) begin
          ctrl_o.prep = PREP_MOVE_NEXT;
          ret_d       = S_FINAL;
          state_d     = S_CHECK;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (stat_i.cmd == CMD_STREAM && stat_i.char_nl) begin
          ctrl_o.prep = PREP_MOVE_NEXT;
        end else if (stat_i.cmd == CMD_STREAM && stat_i.char_cr) begin
          ctrl_o.prep = PREP_MOVE_HOME;
        end else begin
          ctrl_o.prep = PREP_DATA;
        end
        ret_d   = S_OUT;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // drop the rest of the request on the first full-queue failure
        if (stat_i.room_ok) begin
          state_d = S_HI;
        end else begin
          ctrl_o.set_status = 1'b1;
          ctrl_o.status_val = ST_FULL;
          state_d           = S_OUT;
        end
      end
      S_HI: begin
        ctrl_o.push_hi = 1'b1;
        state_d        = S_LO;
      end
      S_LO: begin
        ctrl_o.push_lo = 1'b1;
        state_d        = ret_q;
      end
      S_TICK: begin
        ctrl_o.tick_apply = 1'b1;
        state_d           = S_OUT;
      end
      S_OUT: begin
        // hold the finished item until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.load_out = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_OUT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/char_lcd_nibble_queue_controller.sv
// Character LCD 4-bit front end: requests fill a nibble queue, ticks drive the pins.
// Top level; instantiates clnq_ctrl and clnq_datapath, uses clnq_pkg.
//
// Input channel (in_valid_i / in_stall_o): one item per request or tick, with
// cmd, row, col, char_code, first and cgram_index. Output channel
// (out_valid_o / out_stall_i): one result per item with status, the pin levels
// now driven, the tracked cursor and the queue level.
// Configuration: cfg_we_i writes num_rows (index 0), num_cols (1) or enable (2)
// from cfg_data_i; write only while no item is in flight.
// Sequencing: a tick passes through dispatch and result load, with a queue read
// between them when it reads the queue; a request passes through dispatch and
// result load plus a decision step for each cursor or character step and a room
// check, high and low nibble write for each queued byte. The queue memory has one
// write port, so each byte is written as a high and then a low nibble. One item is
// in work at a time; the next is accepted the cycle after the current result
// enters the output register.
// Reset: queue empty, internal pin levels low, internal cursor at row 0 column 0,
// num_rows 2, num_cols 16, enable 1; the output result registers are not reset.
// No clearing pass; queue entries are written before read. A stalled result holds
// its value; a done item waits in its final state until the output register frees.
module char_lcd_nibble_queue_controller #(
  parameter int unsigned QUEUE_DEPTH = clnq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [2:0] row_i,
  input  logic [5:0] col_i,
  input  logic [7:0] char_code_i,
  input  logic       first_i,
  input  logic [3:0] cgram_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic       pin_en_o,
  output logic       pin_rs_o,
  output logic [3:0] pin_data_o,
  output logic [1:0] cursor_row_o,
  output logic [7:0] cursor_col_o,
  output logic [8:0] queue_level_o
);
  import clnq_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  clnq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  clnq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .char_code_i   (char_code_i),
    .first_i       (first_i),
    .cgram_index_i (cgram_index_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .status_o      (status_o),
    .pin_en_o      (pin_en_o),
    .pin_rs_o      (pin_rs_o),
    .pin_data_o    (pin_data_o),
    .cursor_row_o  (cursor_row_o),
    .cursor_col_o  (cursor_col_o),
    .queue_level_o (queue_level_o)
  );

endmodule
